@@ rtl/swmf_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding window median filter.
// -----------------------------------------------------------------------------
package swmf_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 9;
    localparam int WIN     = 5;
    localparam int WIN_N   = WIN * WIN;
    localparam int RANK_W  = 5;
    localparam int LINES   = 4;
    localparam int WORD_W  = LINES * PIX_W;

    localparam logic [RANK_W-1:0] MID_3X3 = RANK_W'(4);
    localparam logic [RANK_W-1:0] MID_5X5 = RANK_W'(12);

    typedef enum logic [2:0] {
        REG_WINDOW_MODE      = 3'd0,
        REG_LINE_WIDTH       = 3'd1,
        REG_FRAME_HEIGHT     = 3'd2,
        REG_REGION_ROW_FIRST = 3'd3,
        REG_REGION_COL_FIRST = 3'd4,
        REG_REGION_ROW_STOP  = 3'd5,
        REG_REGION_COL_STOP  = 3'd6
    } swmf_reg_t;

    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } swmf_meta_t;

endpackage
`default_nettype wire

@@ rtl/sliding_window_median_filter_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// sliding_window_median_filter_core
// Streaming 3x3 or 5x5 median filter over a raster of grayscale pixels.
// -----------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit up)
// s_       in   tdata: pixel_value[7:0]; tuser: frame_start
// m_       out  tdata: median_value[7:0], centre_row[15:8], centre_col[23:16]
// cfg_     in   cfg_index selects the register, cfg_wdata[8:0] holds the value
//
// One pixel is taken every cycle while no result waits on m_tready; a result is
// registered through the pixel stage, the window and the rank network.
// The line store is read at one column per cycle unless stalled and written back.
// The whole pipeline holds while a result waits on m_tready.
// Reset clears counters and window; the line store needs no clearing.
// -----------------------------------------------------------------------------
module sliding_window_median_filter_core #(
    parameter int MAX_LINE_WIDTH = 256,
    parameter int MAX_FRAME_ROWS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // pixel_value
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // median_value, centre_row, centre_col
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int RW = $clog2(MAX_FRAME_ROWS);
    localparam int MW = (CW > RW) ? CW : RW;
    localparam int GW = (MW + 1 > swmf_pkg::CFG_W) ? MW + 1 : swmf_pkg::CFG_W;
    localparam int PW = swmf_pkg::PIX_W;

    logic                     mode_reg;
    logic [8:0]               line_width_reg;
    logic [8:0]               frame_height_reg;
    logic [7:0]               row_first_reg;
    logic [7:0]               col_first_reg;
    logic [8:0]               row_stop_reg;
    logic [8:0]               col_stop_reg;

    logic [RW-1:0]            row_reg, row_next;
    logic [CW-1:0]            col_reg, col_next;

    logic                     en, accept;
    logic [RW-1:0]            r_cur;
    logic [CW-1:0]            c_cur;
    logic [GW-1:0]            r_ext, c_ext, lw, fh, lw_cfg, fh_cfg, h, two_h;
    logic [GW-1:0]            cr, cc, c_inc, r_inc;
    logic                     emit;

    logic                     p1_valid_reg;
    logic [PW-1:0]            p1_pix_reg;
    logic [1:0]               p1_slot_reg;
    logic [CW-1:0]            p1_col_reg;
    swmf_pkg::swmf_meta_t     p1_meta_reg;

    logic [swmf_pkg::WORD_W-1:0] rd_word, wr_word;
    logic [PW-1:0]            column [swmf_pkg::WIN];
    logic [PW-1:0]            win_reg [swmf_pkg::WIN_N];
    swmf_pkg::swmf_meta_t     meta2_reg;
    swmf_pkg::swmf_meta_t     meta_out;
    logic [PW-1:0]            median_out;
    logic                     wr_en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= 1'b0;
            line_width_reg   <= 9'd160;
            frame_height_reg <= 9'd120;
            row_first_reg    <= 8'd0;
            col_first_reg    <= 8'd0;
            row_stop_reg     <= 9'd120;
            col_stop_reg     <= 9'd160;
        end else if (cfg_wr_en) begin
            unique case (swmf_pkg::swmf_reg_t'(cfg_index))
                swmf_pkg::REG_WINDOW_MODE:      mode_reg         <= cfg_wdata[0];
                swmf_pkg::REG_LINE_WIDTH:       line_width_reg   <= cfg_wdata;
                swmf_pkg::REG_FRAME_HEIGHT:     frame_height_reg <= cfg_wdata;
                swmf_pkg::REG_REGION_ROW_FIRST: row_first_reg    <= cfg_wdata[7:0];
                swmf_pkg::REG_REGION_COL_FIRST: col_first_reg    <= cfg_wdata[7:0];
                swmf_pkg::REG_REGION_ROW_STOP:  row_stop_reg     <= cfg_wdata;
                swmf_pkg::REG_REGION_COL_STOP:  col_stop_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        r_cur  = s_tuser ? '0 : row_reg;
        c_cur  = s_tuser ? '0 : col_reg;
        r_ext  = GW'(r_cur);
        c_ext  = GW'(c_cur);
        lw_cfg = GW'(line_width_reg);
        fh_cfg = GW'(frame_height_reg);
        lw     = (lw_cfg > GW'(MAX_LINE_WIDTH)) ? GW'(MAX_LINE_WIDTH) : lw_cfg;
        fh     = (fh_cfg > GW'(MAX_FRAME_ROWS)) ? GW'(MAX_FRAME_ROWS) : fh_cfg;
        h      = mode_reg ? GW'(2) : GW'(1);
        two_h  = mode_reg ? GW'(4) : GW'(2);
        cr     = r_ext - h;
        cc     = c_ext - h;
        emit   = (r_ext >= two_h) && (c_ext >= two_h) && (r_ext < fh) && (c_ext < lw) &&
                 (cr >= GW'(row_first_reg)) && (cr < GW'(row_stop_reg)) &&
                 (cc >= GW'(col_first_reg)) && (cc < GW'(col_stop_reg));
        c_inc  = c_ext + GW'(1);
        r_inc  = r_ext + GW'(1);
        row_next = r_cur;
        col_next = CW'(c_inc);
        if (c_inc >= lw) begin
            col_next = '0;
            row_next = (r_inc >= fh) ? '0 : RW'(r_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p1_meta_reg  <= '0;
        end else if (en) begin
            p1_valid_reg <= accept;
            if (accept) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                p1_meta_reg <= '{valid: emit, mode: mode_reg, row: cr[7:0], col: cc[7:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg  <= s_tdata;
            p1_slot_reg <= r_cur[1:0];
            p1_col_reg  <= c_cur;
        end
    end

    assign wr_en = p1_valid_reg && en;

    swmf_line_store #(
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .wr_en   (wr_en),
        .wr_addr (p1_col_reg),
        .wr_data (wr_word),
        .rd_data (rd_word)
    );

    always_comb begin
        for (int k = 0; k < swmf_pkg::LINES; k++) begin
            column[k] = rd_word[PW * 32'(2'(p1_slot_reg + 2'(k))) +: PW];
        end
        column[swmf_pkg::WIN-1] = p1_pix_reg;
        wr_word = rd_word;
        wr_word[PW * 32'(p1_slot_reg) +: PW] = p1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swmf_pkg::WIN_N; i++) begin
                win_reg[i] <= '0;
            end
            meta2_reg <= '0;
        end else if (en) begin
            meta2_reg <= '{valid: p1_valid_reg && p1_meta_reg.valid,
                           mode:  p1_meta_reg.mode,
                           row:   p1_meta_reg.row,
                           col:   p1_meta_reg.col};
            if (p1_valid_reg) begin
                for (int i = 0; i < swmf_pkg::WIN; i++) begin
                    for (int j = 0; j < swmf_pkg::WIN - 1; j++) begin
                        win_reg[i * swmf_pkg::WIN + j] <= win_reg[i * swmf_pkg::WIN + j + 1];
                    end
                    win_reg[i * swmf_pkg::WIN + swmf_pkg::WIN - 1] <= column[i];
                end
            end
        end
    end

    swmf_median u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .meta_in    (meta2_reg),
        .win_in     (win_reg),
        .meta_out   (meta_out),
        .median_out (median_out)
    );

    assign m_tvalid = meta_out.valid;
    assign m_tdata  = {meta_out.col, meta_out.row, median_out};

endmodule
`default_nettype wire

@@ rtl/swmf_line_store.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// swmf_line_store
// Four line stores packed in one word per column, with write-to-read bypass.
// -----------------------------------------------------------------------------
module swmf_line_store #(
    parameter int DEPTH = 256
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [swmf_pkg::WORD_W-1:0] wr_data,
    output logic      [swmf_pkg::WORD_W-1:0] rd_data
);

    logic [swmf_pkg::WORD_W-1:0] mem [DEPTH];
    logic [swmf_pkg::WORD_W-1:0] q_reg;
    logic [swmf_pkg::WORD_W-1:0] fwd_data_reg;
    logic                        fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule
`default_nettype wire

@@ rtl/swmf_median.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// swmf_median
// Three-stage rank network: pairwise compares, rank counts, median select.
// -----------------------------------------------------------------------------
module swmf_median (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire swmf_pkg::swmf_meta_t       meta_in,
    input  wire logic [swmf_pkg::PIX_W-1:0] win_in [swmf_pkg::WIN_N],
    output swmf_pkg::swmf_meta_t            meta_out,
    output logic      [swmf_pkg::PIX_W-1:0] median_out
);

    localparam int N = swmf_pkg::WIN_N;

    logic [N-1:0]                act_in;
    logic [N-1:0]                cmp_next [N];
    logic [N-1:0]                cmp_reg [N];
    logic [N-1:0]                act_a_reg;
    logic [swmf_pkg::PIX_W-1:0]  val_a_reg [N];
    swmf_pkg::swmf_meta_t        meta_a_reg;

    logic [swmf_pkg::RANK_W-1:0] rank_reg [N];
    logic [N-1:0]                act_b_reg;
    logic [swmf_pkg::PIX_W-1:0]  val_b_reg [N];
    swmf_pkg::swmf_meta_t        meta_b_reg;

    logic [swmf_pkg::RANK_W-1:0] target;
    logic [swmf_pkg::PIX_W-1:0]  median_next;
    logic [swmf_pkg::PIX_W-1:0]  median_reg;
    swmf_pkg::swmf_meta_t        meta_c_reg;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            act_in[i] = meta_in.mode || ((i / swmf_pkg::WIN) >= 2 && (i % swmf_pkg::WIN) >= 2);
        end
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                cmp_next[i][j] = act_in[j] &&
                    ((win_in[j] < win_in[i]) || ((win_in[j] == win_in[i]) && (j < i)));
            end
        end
    end

    assign target = meta_b_reg.mode ? swmf_pkg::MID_5X5 : swmf_pkg::MID_3X3;

    always_comb begin
        median_next = '0;
        for (int i = 0; i < N; i++) begin
            if (act_b_reg[i] && (rank_reg[i] == target)) begin
                median_next = median_next | val_b_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                cmp_reg[i]   <= cmp_next[i];
                val_a_reg[i] <= win_in[i];
                rank_reg[i]  <= swmf_pkg::RANK_W'($countones(cmp_reg[i]));
                val_b_reg[i] <= val_a_reg[i];
            end
            act_a_reg  <= act_in;
            act_b_reg  <= act_a_reg;
            median_reg <= median_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_a_reg <= '0;
            meta_b_reg <= '0;
            meta_c_reg <= '0;
        end else if (en) begin
            meta_a_reg <= meta_in;
            meta_b_reg <= meta_a_reg;
            meta_c_reg <= meta_b_reg;
        end
    end

    assign meta_out   = meta_c_reg;
    assign median_out = median_reg;

endmodule
`default_nettype wire

@@ rtl/swmf_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// swmf_checker
// Port-level checks of the median filter core, bound to the top level.
// -----------------------------------------------------------------------------
module swmf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while its transfer was stalled.");

    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Input taken while the pipeline is stalled.");

    a_free_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input refused with no result pending.");

    a_reset_quiet: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("Result shown right after reset.");

endmodule

bind sliding_window_median_filter_core swmf_checker u_swmf_checker (.*);
`default_nettype wire
